### src/work_stealing_job_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Work-stealing job scheduler assertion macros
// Concurrent check wrappers, clocked on clk and disabled during rst_n low.
// ----------------------------------------------------------------------------
`ifndef WORK_STEALING_JOB_SCHEDULER_ASSERT_SVH
`define WORK_STEALING_JOB_SCHEDULER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define WSJS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed: same-cycle implication");

// Next-cycle implication
`define WSJS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed: next-cycle implication");

// Invariant on every edge
`define WSJS_ASSERT_HOLD(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("scheduler check failed: invariant");

`else

`define WSJS_ASSERT_IMP(lbl, ante, cons)
`define WSJS_ASSERT_NXT(lbl, ante, cons)
`define WSJS_ASSERT_HOLD(lbl, cond)

`endif

`endif

### src/wsjs_pkg.sv
// ----------------------------------------------------------------------------
// wsjs_pkg
// Shared sizes, codes and types of the work-stealing job scheduler.
// ----------------------------------------------------------------------------
package wsjs_pkg;

  // Sizing; QUEUE_DEPTH must stay a power of two (slot indexes wrap by width)
  localparam int MAX_WORKERS = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int JOB_BITS    = 32;

  localparam int WID_W  = $clog2(MAX_WORKERS);
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = QIDX_W + 1;
  localparam int ADDR_W = WID_W + QIDX_W;
  localparam int WC_W   = 4;
  localparam int PEND_W = 8;
  localparam int REQ_W  = 2;

  localparam logic [PEND_W-1:0] PENDING_MAX = 8'd255;
  localparam logic [WC_W-1:0]   WC_RESET    = WC_W'(MAX_WORKERS);

  // Request codes; the remaining code is an unused request
  localparam logic [REQ_W-1:0] REQ_SUBMIT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FETCH    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPLETE = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NO_JOB     = 3'd2,
    ST_NO_PENDING = 3'd3,
    ST_BAD_WORKER = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } fsm_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_out;
  } ctrl_cmd_t;

endpackage

### src/wsjs_ctrl.sv
// ----------------------------------------------------------------------------
// wsjs_ctrl
// Sequencer: capture a request, execute it, then hand the result to the
// output register. Owns both channel handshakes.
// ----------------------------------------------------------------------------
`include "work_stealing_job_scheduler_assert.svh"

module wsjs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output wsjs_pkg::ctrl_cmd_t  cmd
);
  import wsjs_pkg::*;

  fsm_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // Output register can take a new beat
  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = in_tvalid ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_tready    = 1'b0;
    cmd.execute  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
      end
      S_RESP: begin
        in_tready    = out_free;
        cmd.load_out = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    cmd.capture = in_tvalid && in_tready;
  end

  // Output valid: set on load, drop once the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `WSJS_ASSERT_NXT(a_exec_then_resp, state_r == S_EXEC, state_r == S_RESP)
  `WSJS_ASSERT_IMP(a_no_overwrite, out_valid_r && !out_tready, !cmd.load_out)
  `WSJS_ASSERT_NXT(a_load_shows, cmd.load_out, out_valid_r)

endmodule

### src/wsjs_dp.sv
// ----------------------------------------------------------------------------
// wsjs_dp
// Queue state, job memory, steal pick and result registers.
// ----------------------------------------------------------------------------
`include "work_stealing_job_scheduler_assert.svh"

module wsjs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wsjs_pkg::ctrl_cmd_t                 cmd,
  input  logic [wsjs_pkg::REQ_W-1:0]          in_req_type,
  input  logic [wsjs_pkg::WID_W-1:0]          in_worker_index,
  input  logic [wsjs_pkg::JOB_BITS-1:0]       in_job_handle,
  input  logic                                cfg_we,
  input  logic [wsjs_pkg::WC_W-1:0]           cfg_wdata,
  output logic [wsjs_pkg::WC_W-1:0]           worker_count,
  output wsjs_pkg::status_t                   res_status,
  output logic                                res_job_granted,
  output logic [wsjs_pkg::JOB_BITS-1:0]       res_job_out,
  output logic [wsjs_pkg::WID_W-1:0]          res_source_worker,
  output logic                                res_was_stolen,
  output logic [wsjs_pkg::PEND_W-1:0]         res_pending_count,
  output logic                                res_all_idle
);
  import wsjs_pkg::*;

  // Lowest set bit index
  function automatic logic [WID_W-1:0] lowest_set(input logic [MAX_WORKERS-1:0] v);
    logic [WID_W-1:0] idx;
    idx = '0;
    for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
      if (v[i]) idx = WID_W'(i);
    end
    return idx;
  endfunction

  // Captured request
  logic [REQ_W-1:0]    req_r;
  logic [WID_W-1:0]    who_r;
  logic [JOB_BITS-1:0] job_r;

  // Scheduler state
  logic [WC_W-1:0]   wc_r;
  logic [QIDX_W-1:0] head_r   [MAX_WORKERS];
  logic [QIDX_W-1:0] head_nxt [MAX_WORKERS];
  logic [FILL_W-1:0] fill_r   [MAX_WORKERS];
  logic [FILL_W-1:0] fill_nxt [MAX_WORKERS];
  logic [WID_W-1:0]  sp_r, sp_nxt;
  logic [PEND_W-1:0] pending_r, pending_nxt;

  logic [JOB_BITS-1:0] job_mem [MAX_WORKERS*QUEUE_DEPTH];
  logic [JOB_BITS-1:0] rdata_r;

  // Staged result of the executed request
  status_t           stg_status_r, stg_status;
  logic              stg_granted_r, stg_granted;
  logic [WID_W-1:0]  stg_src_r, stg_src;
  logic              stg_stolen_r, stg_stolen;

  // Output register
  status_t             out_status_r;
  logic                out_granted_r;
  logic [JOB_BITS-1:0] out_job_r;
  logic [WID_W-1:0]    out_src_r;
  logic                out_stolen_r;
  logic [PEND_W-1:0]   out_pending_r;
  logic                out_idle_r;

  logic [WC_W-1:0]        n_act;
  logic [WID_W-1:0]       sub_q;
  logic                   sub_ok;
  logic [WC_W-1:0]        sub_q_inc;
  logic [MAX_WORKERS-1:0] cand;
  logic [MAX_WORKERS-1:0] cand_hi;
  logic [WID_W-1:0]       pick;
  logic                   mem_we;
  logic                   mem_re;
  logic [ADDR_W-1:0]      mem_addr;
  logic                   fill_ok;

  // Clamp worker count into 1..MAX_WORKERS
  always_comb begin
    if (wc_r == '0) begin
      n_act = WC_W'(1);
    end else if (wc_r > WC_W'(MAX_WORKERS)) begin
      n_act = WC_W'(MAX_WORKERS);
    end else begin
      n_act = wc_r;
    end
  end

  // Submit target: round-robin pointer, queue 0 once the count shrank to or below it
  always_comb begin
    sub_q     = ({{(WC_W-WID_W){1'b0}}, sp_r} < n_act) ? sp_r : '0;
    sub_ok    = (fill_r[sub_q] < FILL_W'(QUEUE_DEPTH)) && (pending_r != PENDING_MAX);
    sub_q_inc = {{(WC_W-WID_W){1'b0}}, sub_q} + WC_W'(1);
  end

  // Steal candidates: other active workers with jobs, scanned from worker+1
  always_comb begin
    for (int i = 0; i < MAX_WORKERS; i++) begin
      cand[i]    = (fill_r[i] != '0) && (WC_W'(i) < n_act) && (WID_W'(i) != who_r);
      cand_hi[i] = cand[i] && (WID_W'(i) > who_r);
    end
    pick = (|cand_hi) ? lowest_set(cand_hi) : lowest_set(cand);
  end

  // Execute the request: state updates, memory access, staged result
  always_comb begin
    for (int i = 0; i < MAX_WORKERS; i++) begin
      head_nxt[i] = head_r[i];
      fill_nxt[i] = fill_r[i];
    end
    sp_nxt      = sp_r;
    pending_nxt = pending_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = '0;
    stg_status  = ST_NO_JOB;
    stg_granted = 1'b0;
    stg_src     = '0;
    stg_stolen  = 1'b0;

    if (req_r == REQ_SUBMIT) begin
      stg_src = sub_q;
      if (sub_ok) begin
        mem_we          = 1'b1;
        mem_addr        = {sub_q, head_r[sub_q] + fill_r[sub_q][QIDX_W-1:0]};
        fill_nxt[sub_q] = fill_r[sub_q] + FILL_W'(1);
        pending_nxt     = pending_r + PEND_W'(1);
        sp_nxt          = (sub_q_inc >= n_act) ? '0 : sub_q_inc[WID_W-1:0];
        stg_status      = ST_OK;
      end else begin
        stg_status = ST_FULL;
      end
    end else if (req_r == REQ_FETCH) begin
      if ({{(WC_W-WID_W){1'b0}}, who_r} >= n_act) begin
        stg_status = ST_BAD_WORKER;
      end else if (fill_r[who_r] != '0) begin
        // Pop newest from own back
        mem_re          = 1'b1;
        mem_addr        = {who_r,
                           head_r[who_r] + fill_r[who_r][QIDX_W-1:0] - QIDX_W'(1)};
        fill_nxt[who_r] = fill_r[who_r] - FILL_W'(1);
        stg_status      = ST_OK;
        stg_granted     = 1'b1;
        stg_src         = who_r;
      end else if (|cand) begin
        // Steal oldest from another front
        mem_re         = 1'b1;
        mem_addr       = {pick, head_r[pick]};
        head_nxt[pick] = head_r[pick] + QIDX_W'(1);
        fill_nxt[pick] = fill_r[pick] - FILL_W'(1);
        stg_status     = ST_OK;
        stg_granted    = 1'b1;
        stg_src        = pick;
        stg_stolen     = 1'b1;
      end
    end else if (req_r == REQ_COMPLETE) begin
      if (pending_r == '0) begin
        stg_status = ST_NO_PENDING;
      end else begin
        pending_nxt = pending_r - PEND_W'(1);
        stg_status  = ST_OK;
      end
    end
  end

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      who_r <= in_worker_index;
      job_r <= in_job_handle;
    end
  end

  // Queue state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r      <= WC_RESET;
      sp_r      <= '0;
      pending_r <= '0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      if (cfg_we) wc_r <= cfg_wdata;
      if (cmd.execute) begin
        sp_r      <= sp_nxt;
        pending_r <= pending_nxt;
        for (int i = 0; i < MAX_WORKERS; i++) begin
          head_r[i] <= head_nxt[i];
          fill_r[i] <= fill_nxt[i];
        end
      end
    end
  end

  // Job memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.execute && mem_we) job_mem[mem_addr] <= job_r;
    if (cmd.execute && mem_re) rdata_r <= job_mem[mem_addr];
  end

  // Stage the result, then move it to the output register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      stg_status_r  <= stg_status;
      stg_granted_r <= stg_granted;
      stg_src_r     <= stg_src;
      stg_stolen_r  <= stg_stolen;
    end
    if (cmd.load_out) begin
      out_status_r  <= stg_status_r;
      out_granted_r <= stg_granted_r;
      out_job_r     <= stg_granted_r ? rdata_r : '0;
      out_src_r     <= stg_src_r;
      out_stolen_r  <= stg_stolen_r;
      out_pending_r <= pending_r;
      out_idle_r    <= (pending_r == '0);
    end
  end

  assign worker_count      = wc_r;
  assign res_status        = out_status_r;
  assign res_job_granted   = out_granted_r;
  assign res_job_out       = out_job_r;
  assign res_source_worker = out_src_r;
  assign res_was_stolen    = out_stolen_r;
  assign res_pending_count = out_pending_r;
  assign res_all_idle      = out_idle_r;

  // Every queue holds at most its depth
  always_comb begin
    fill_ok = 1'b1;
    for (int i = 0; i < MAX_WORKERS; i++) begin
      if (fill_r[i] > FILL_W'(QUEUE_DEPTH)) fill_ok = 1'b0;
    end
  end

  `WSJS_ASSERT_HOLD(a_fill_bound, fill_ok)
  `WSJS_ASSERT_IMP(a_grant_ok, cmd.execute && stg_granted, stg_status == ST_OK)
  `WSJS_ASSERT_NXT(a_pend_inc, cmd.execute && (req_r == REQ_SUBMIT) && sub_ok,
                   pending_r == $past(pending_r) + PEND_W'(1))

endmodule

### src/work_stealing_job_scheduler.sv
// Path: request capture, staging registers, then the output register once free.
// Requests: one at a time; the next beat is taken in the cycle the result loads,
//   as the execute step goes over the single-port job memory.
// The output register holds a stalled result while a new request is captured.
// Reset (rst_n low, synchronous): queues empty, pending count and submit pointer
//   zero, worker_count = 8. Job memory is not cleared; no clearing pass.
// ----------------------------------------------------------------------------
// work_stealing_job_scheduler
// Per-worker job deques with round-robin submit, own-back fetch and steal
// from other workers' fronts, plus a pending job count.
// ----------------------------------------------------------------------------
module work_stealing_job_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: req_type[1:0], worker_index[4:2], job_handle[36:5], zero[39:37]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // out_tdata: status[2:0], job_granted[3], job_out[35:4], source_worker[38:36],
  //            was_stolen[39], pending_count[47:40], all_idle[48], zero[55:49]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import wsjs_pkg::*;

  localparam logic CFG_IDX_WORKER_COUNT = 1'b0;

  ctrl_cmd_t           cmd;
  logic                cfg_we;
  logic [WC_W-1:0]     worker_count;
  status_t             res_status;
  logic                res_job_granted;
  logic [JOB_BITS-1:0] res_job_out;
  logic [WID_W-1:0]    res_source_worker;
  logic                res_was_stolen;
  logic [PEND_W-1:0]   res_pending_count;
  logic                res_all_idle;

  // Register port: write on access phase, reads always ready
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == CFG_IDX_WORKER_COUNT);
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_WORKER_COUNT) ?
                      {{(32-WC_W){1'b0}}, worker_count} : '0;

  wsjs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  wsjs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_req_type       (in_tdata[1:0]),
    .in_worker_index   (in_tdata[4:2]),
    .in_job_handle     (in_tdata[36:5]),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_pwdata[WC_W-1:0]),
    .worker_count      (worker_count),
    .res_status        (res_status),
    .res_job_granted   (res_job_granted),
    .res_job_out       (res_job_out),
    .res_source_worker (res_source_worker),
    .res_was_stolen    (res_was_stolen),
    .res_pending_count (res_pending_count),
    .res_all_idle      (res_all_idle)
  );

  // Pack the result beat
  assign out_tdata = {7'b0, res_all_idle, res_pending_count, res_was_stolen,
                      res_source_worker, res_job_out, res_job_granted,
                      3'(res_status)};

endmodule

### sim/work_stealing_job_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// work_stealing_job_scheduler_tb
// Streams submit, fetch and complete requests into the scheduler and checks
// every result beat against a cycle-free model of the per-worker deques, the
// round-robin submit pointer and the pending job count. Directed requests hit
// the corner cases first. Random traffic then runs under several worker counts,
// with random idling on both sides, one long output hold-off and a run that
// drives the pending count into saturation.
// ----------------------------------------------------------------------------
module work_stealing_job_scheduler_tb;
  import wsjs_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED       = 2'd3;
  localparam logic [2:0]       REG_WORKER_COUNT = 3'd0;
  localparam int               IDLE_PCT         = 12;
  localparam int               LONG_HOLD        = 120;
  localparam int               SEG_ITEMS        = 60;
  localparam int               REQ_SLOTS        = 2048;

  typedef struct {
    status_t               status;
    logic                  granted;
    logic [JOB_BITS-1:0]   job;
    logic [WID_W-1:0]      src;
    logic                  stolen;
    logic [PEND_W-1:0]     pending;
    logic                  idle;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // in_tdata: req_type[1:0], worker_index[4:2], job_handle[36:5], zero[39:37]
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // out_tdata: status[2:0], job_granted[3], job_out[35:4], source_worker[38:36],
  //            was_stolen[39], pending_count[47:40], all_idle[48], zero[55:49]
  logic [55:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Scheduler model state
  logic [JOB_BITS-1:0] job_mem [MAX_WORKERS][QUEUE_DEPTH];
  int unsigned         q_head [MAX_WORKERS] = '{default: 0};
  int unsigned         q_fill [MAX_WORKERS] = '{default: 0};
  int unsigned         rr_ptr = 0;
  int unsigned         pend_model = 0;
  int unsigned         wc_model = MAX_WORKERS;

  // Stimulus and scoreboard bookkeeping: circular buffers with read and write counts
  logic [36:0]  request_q [REQ_SLOTS];
  grant_t       awaited_grants [REQ_SLOTS];
  int unsigned  req_wr = 0;
  int unsigned  req_rd = 0;
  int unsigned  grant_wr = 0;
  int unsigned  grant_rd = 0;
  int unsigned  n_issued = 0;
  int unsigned  n_accepted = 0;
  int unsigned  n_errors = 0;
  bit           beat_taken = 1'b0;
  bit           calm = 1'b0;
  int unsigned  holds_asked = 0;
  int unsigned  holds_done = 0;
  int unsigned  hold_left = 0;

  work_stealing_job_scheduler i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one request to the model and return the result it should produce
  function automatic grant_t schedule_request(logic [1:0] kind, logic [2:0] who,
                                              logic [JOB_BITS-1:0] handle);
    grant_t      g;
    int unsigned n;
    int unsigned q;
    int unsigned slot;
    int unsigned v;
    bit          found;
    g = '{ST_NO_JOB, 1'b0, '0, '0, 1'b0, '0, 1'b0};
    n = (wc_model == 0) ? 1 : (wc_model > MAX_WORKERS) ? MAX_WORKERS : wc_model;
    case (kind)
      REQ_SUBMIT: begin
        q = (rr_ptr < n) ? rr_ptr : 0;
        g.src = q[WID_W-1:0];
        if (q_fill[q] >= QUEUE_DEPTH || pend_model >= PENDING_MAX) begin
          g.status = ST_FULL;
        end else begin
          slot = (q_head[q] + q_fill[q]) % QUEUE_DEPTH;
          job_mem[q][slot] = handle;
          q_fill[q]++;
          pend_model++;
          rr_ptr = (q + 1 >= n) ? 0 : q + 1;
          g.status = ST_OK;
        end
      end
      REQ_FETCH: begin
        if (who >= n) begin
          g.status = ST_BAD_WORKER;
        end else if (q_fill[who] != 0) begin
          // own queue: newest job from the back
          slot = (q_head[who] + q_fill[who] - 1) % QUEUE_DEPTH;
          q_fill[who]--;
          g.job = job_mem[who][slot];
          g.granted = 1'b1;
          g.src = who;
          g.status = ST_OK;
        end else begin
          // steal the oldest job of the first non-empty queue after who
          found = 1'b0;
          for (int unsigned off = 1; off < n; off++) begin
            v = (who + off) % n;
            if (!found && q_fill[v] != 0) begin
              found = 1'b1;
              slot = q_head[v];
              q_head[v] = (slot + 1) % QUEUE_DEPTH;
              q_fill[v]--;
              g.job = job_mem[v][slot];
              g.granted = 1'b1;
              g.stolen = 1'b1;
              g.src = v[WID_W-1:0];
              g.status = ST_OK;
            end
          end
        end
      end
      REQ_COMPLETE: begin
        if (pend_model == 0) begin
          g.status = ST_NO_PENDING;
        end else begin
          pend_model--;
          g.status = ST_OK;
        end
      end
      default: ;
    endcase
    g.pending = pend_model[PEND_W-1:0];
    g.idle = (pend_model == 0);
    return g;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  task automatic push_request(logic [1:0] kind, logic [2:0] who,
                              logic [JOB_BITS-1:0] handle);
    request_q[req_wr % REQ_SLOTS] = {handle, who, kind};
    req_wr++;
    n_issued++;
  endtask

  // Mostly well-formed traffic; a fifth of the worker indexes span all eight
  task automatic push_random(int unsigned n_act);
    int unsigned r;
    logic [1:0]  kind;
    logic [2:0]  who;
    r = $urandom_range(99);
    kind = (r < 40) ? REQ_SUBMIT : (r < 75) ? REQ_FETCH :
           (r < 95) ? REQ_COMPLETE : REQ_UNUSED;
    who = ($urandom_range(99) < 80) ? 3'($urandom_range(n_act - 1, 0))
                                    : 3'($urandom_range(7, 0));
    push_request(kind, who, $urandom());
  endtask

  // Hold until every request is taken and every result has come back
  task automatic drain_traffic();
    while (n_accepted != n_issued || grant_wr != grant_rd) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_workers(logic [3:0] value);
    drain_traffic();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_WORKER_COUNT;
    cfg_pwdata <= {28'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    wc_model = value;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Input side: record each accepted beat and predict its result
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      awaited_grants[grant_wr % REQ_SLOTS] = schedule_request(in_tdata[1:0],
                                                              in_tdata[4:2],
                                                              in_tdata[36:5]);
      grant_wr++;
      n_accepted++;
      beat_taken = 1'b1;
    end
  end

  // Driver: hold a beat until taken, then offer the next or idle
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || beat_taken)) begin
      if (req_wr != req_rd && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_tdata <= {3'b000, request_q[req_rd % REQ_SLOTS]};
        req_rd++;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    beat_taken = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (holds_done != holds_asked) begin
      hold_left = LONG_HOLD;
      holds_done++;
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (grant_wr == grant_rd) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, out_tdata);
        n_errors++;
      end else begin
        want = awaited_grants[grant_rd % REQ_SLOTS];
        grant_rd++;
        check_field("status", want.status, out_tdata[2:0]);
        check_field("job_granted", want.granted, out_tdata[3]);
        check_field("job_out", want.job, out_tdata[35:4]);
        check_field("source_worker", want.src, out_tdata[38:36]);
        check_field("was_stolen", want.stolen, out_tdata[39]);
        check_field("pending_count", want.pending, out_tdata[47:40]);
        check_field("all_idle", want.idle, out_tdata[48]);
      end
    end
  end

  initial begin : stimulus
    int unsigned seg_workers;
    int unsigned occ;
    int unsigned start_ptr;
    int          extra_pairs;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Empty scheduler: complete with nothing pending, fetch with no job, unused code
    push_request(REQ_COMPLETE, 3'd5, 32'h1234_5678);
    push_request(REQ_FETCH, 3'd7, '0);
    push_request(REQ_UNUSED, 3'd0, 32'hFFFF_FFFF);
    // One job in each of queues 0..3, then own-back fetches and steals
    push_request(REQ_SUBMIT, 3'd0, 32'h0000_0000);
    push_request(REQ_SUBMIT, 3'd7, 32'hFFFF_FFFF);
    push_request(REQ_SUBMIT, 3'd2, 32'hA5A5_5A5A);
    push_request(REQ_SUBMIT, 3'd2, 32'h8000_0001);
    push_request(REQ_FETCH, 3'd1, 32'hDEAD_BEEF);
    push_request(REQ_FETCH, 3'd5, '0);
    push_request(REQ_FETCH, 3'd3, '0);
    push_request(REQ_FETCH, 3'd4, '0);
    push_request(REQ_FETCH, 3'd6, '0);
    repeat (5) push_request(REQ_COMPLETE, 3'd0, '0);
    push_request(REQ_SUBMIT, 3'd3, 32'h7FFF_FFFE);
    push_request(REQ_COMPLETE, 3'd7, 32'hFFFF_FFFF);
    push_request(REQ_COMPLETE, 3'd2, 32'h5A5A_A5A5);

    // Zero workers acts as one: fill queue 0 past full, bad worker fetches
    write_workers(4'd0);
    repeat (17) push_request(REQ_SUBMIT, 3'($urandom_range(7, 0)), $urandom());
    push_request(REQ_FETCH, 3'd1, '0);
    repeat (4) push_request(REQ_FETCH, 3'd0, '0);
    push_request(REQ_FETCH, 3'd7, '0);

    // Three workers, then shrink so the submit pointer lies beyond the count
    write_workers(4'd3);
    repeat (5) push_request(REQ_SUBMIT, 3'd0, $urandom());
    write_workers(4'd2);
    push_request(REQ_SUBMIT, 3'd1, $urandom());
    push_request(REQ_FETCH, 3'd2, '0);
    push_request(REQ_FETCH, 3'd1, '0);
    // Counts above the maximum act as eight; queue 2 becomes reachable again
    write_workers(4'd15);
    push_request(REQ_FETCH, 3'd2, '0);
    push_request(REQ_FETCH, 3'd6, '0);
    push_request(REQ_SUBMIT, 3'd0, $urandom());
    write_workers(4'd9);
    push_request(REQ_FETCH, 3'd7, '0);
    push_request(REQ_SUBMIT, 3'd4, $urandom());

    // Random traffic under several worker counts; last segment without idling
    for (int seg = 0; seg < 4; seg++) begin
      seg_workers = (seg == 1) ? $urandom_range(2, 7) : (seg == 2) ? 1 : MAX_WORKERS;
      write_workers(4'(seg_workers));
      calm = (seg == 3);
      repeat (SEG_ITEMS) push_random(seg_workers);
      if (seg == 3) holds_asked++;
    end
    drain_traffic();
    calm = 1'b0;

    // Drive the pending count to its ceiling: empty every queue, refill them all,
    // then pair each fetch with a submit into the queue that fetch just freed
    write_workers(4'(MAX_WORKERS));
    occ = 0;
    for (int i = 0; i < MAX_WORKERS; i++) occ += q_fill[i];
    start_ptr = rr_ptr;
    repeat (occ) push_request(REQ_FETCH, 3'd0, '0);
    repeat (MAX_WORKERS * QUEUE_DEPTH)
      push_request(REQ_SUBMIT, 3'($urandom_range(7, 0)), $urandom());
    extra_pairs = int'(PENDING_MAX) - int'(pend_model) - MAX_WORKERS * QUEUE_DEPTH + 4;
    for (int k = 0; k < extra_pairs; k++) begin
      push_request(REQ_FETCH, 3'((start_ptr + k) % MAX_WORKERS), '0);
      push_request(REQ_SUBMIT, 3'($urandom_range(7, 0)), $urandom());
    end
    repeat (20) push_request(REQ_COMPLETE, 3'($urandom_range(7, 0)), $urandom());
    repeat (4) push_request(REQ_SUBMIT, 3'd0, $urandom());

    drain_traffic();
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
